// ===== design/lpcr_pkg.sv =====
// Shared types and constants for the length-prefixed command receiver.
// No dependencies.
`timescale 1ns / 1ps

package lpcr_pkg;

	// Result status codes
	localparam logic [2:0] ST_NOTHING  = 3'd0;
	localparam logic [2:0] ST_TAKEN    = 3'd1;
	localparam logic [2:0] ST_PAN      = 3'd2;
	localparam logic [2:0] ST_ADDRESS  = 3'd3;
	localparam logic [2:0] ST_COMMIT   = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;
	localparam logic [2:0] ST_TIMEOUT  = 3'd6;
	localparam logic [2:0] ST_OVERFLOW = 3'd7;

	// Configuration register indexes
	localparam logic [1:0] REG_PAN_CODE  = 2'd0;
	localparam logic [1:0] REG_ADDR_CODE = 2'd1;
	localparam logic [1:0] REG_COMMIT    = 2'd2;
	localparam logic [1:0] REG_TIMEOUT   = 2'd3;

	// Only the command byte and the eight bytes after it are ever decoded
	localparam int HEAD_BYTES = 9;

	typedef logic [HEAD_BYTES-1:0][7:0] head_t;

	// Framer to decoder: per-step framing result
	typedef struct packed {
		logic       done;    // last payload byte of a frame in this step
		logic [2:0] status;  // framing status when not done
		head_t      head;    // frame head bytes as seen after this step's write
	} frm_res_t;

endpackage

// ===== design/lpcr_framer.sv =====
// Frame tracking for the receiver: length count, write position, timeout
// and the frame head bytes. Depends on lpcr_pkg.
`timescale 1ns / 1ps

module lpcr_framer import lpcr_pkg::*; #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic        command,
	input  logic [7:0]  data_byte,
	input  logic [15:0] timeout_ticks,
	output frm_res_t    res
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);

	logic             in_payload_q;
	logic [7:0]       bytes_left_q;
	logic [IDX_W-1:0] write_index_q;
	logic             store_full_q;
	logic [15:0]      tick_count_q;
	logic [7:0]       head_q [HEAD_BYTES];

	logic [15:0] tick_inc;
	logic        timed_out;
	logic [7:0]  bytes_left_dec;
	logic        wr;
	logic        last_slot;

	assign tick_inc       = (tick_count_q == 16'hFFFF) ? tick_count_q : tick_count_q + 16'd1;
	assign timed_out      = tick_inc >= timeout_ticks;
	assign bytes_left_dec = bytes_left_q - 8'd1;
	assign wr             = !command && in_payload_q && !store_full_q;
	assign last_slot      = ({1'b0, write_index_q} + (IDX_W+1)'(1)) >= (IDX_W+1)'(BUFFER_DEPTH);

	always_comb begin
		res.done   = 1'b0;
		res.status = ST_NOTHING;
		if (command) begin
			if (in_payload_q && timed_out) res.status = ST_TIMEOUT;
		end else if (!in_payload_q) begin
			res.status = ST_TAKEN;
		end else if (bytes_left_dec == 8'd0) begin
			res.done = 1'b1;
		end else begin
			res.status = store_full_q ? ST_OVERFLOW : ST_TAKEN;
		end
		// head bytes with this step's byte bypassed in
		for (int k = 0; k < HEAD_BYTES; k++) begin
			res.head[k] = (wr && write_index_q == IDX_W'(k)) ? data_byte : head_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q  <= 1'b0;
			bytes_left_q  <= 8'd0;
			write_index_q <= '0;
			store_full_q  <= 1'b0;
			tick_count_q  <= 16'd0;
		end else if (step_en) begin
			if (command) begin
				if (in_payload_q) begin
					if (timed_out) begin
						in_payload_q  <= 1'b0;
						bytes_left_q  <= 8'd0;
						write_index_q <= '0;
						store_full_q  <= 1'b0;
						tick_count_q  <= 16'd0;
					end else begin
						tick_count_q <= tick_inc;
					end
				end
			end else if (!in_payload_q) begin
				in_payload_q  <= 1'b1;
				bytes_left_q  <= data_byte;
				write_index_q <= '0;
				store_full_q  <= 1'b0;
				tick_count_q  <= 16'd0;
			end else if (bytes_left_dec == 8'd0) begin
				in_payload_q  <= 1'b0;
				bytes_left_q  <= 8'd0;
				write_index_q <= '0;
				store_full_q  <= 1'b0;
				tick_count_q  <= 16'd0;
			end else begin
				bytes_left_q <= bytes_left_dec;
				if (!store_full_q) begin
					if (last_slot) store_full_q <= 1'b1;
					else write_index_q <= write_index_q + IDX_W'(1);
				end
			end
		end
	end

	// head store: payload only, undefined until written
	always_ff @(posedge clk) begin
		if (step_en) begin
			for (int k = 0; k < HEAD_BYTES; k++) begin
				if (wr && write_index_q == IDX_W'(k)) head_q[k] <= data_byte;
			end
		end
	end

endmodule

// ===== design/lpcr_decoder.sv =====
// Command decode on frame completion and the stored PAN id and address.
// Depends on lpcr_pkg.
`timescale 1ns / 1ps

module lpcr_decoder import lpcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  frm_res_t    frm,
	input  logic [7:0]  pan_id_code,
	input  logic [7:0]  address_code,
	input  logic [7:0]  commit_code,
	output logic [2:0]  status,
	output logic [15:0] pan_next,
	output logic [63:0] addr_next
);

	logic [15:0] stored_pan_q;
	logic [63:0] stored_addr_q;
	logic [2:0]  cmd_status;

	always_comb begin
		pan_next  = stored_pan_q;
		addr_next = stored_addr_q;
		priority if (frm.head[0] == pan_id_code) begin
			cmd_status = ST_PAN;
			if (frm.done) pan_next = {frm.head[1], frm.head[2]};
		end else if (frm.head[0] == address_code) begin
			cmd_status = ST_ADDRESS;
			if (frm.done) addr_next = {frm.head[8], frm.head[7], frm.head[6], frm.head[5],
			                           frm.head[4], frm.head[3], frm.head[2], frm.head[1]};
		end else if (frm.head[0] == commit_code) begin
			cmd_status = ST_COMMIT;
		end else begin
			cmd_status = ST_UNKNOWN;
		end
		status = frm.done ? cmd_status : frm.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_pan_q  <= 16'd0;
			stored_addr_q <= 64'd0;
		end else if (step_en) begin
			stored_pan_q  <= pan_next;
			stored_addr_q <= addr_next;
		end
	end

endmodule

// ===== design/length_prefixed_command_receiver.sv =====
// Top level of the length-prefixed command receiver: input register,
// config registers, output register. Depends on lpcr_pkg, lpcr_framer, lpcr_decoder.
`timescale 1ns / 1ps

// Length-prefixed command receiver. Each input transfer is either a received
// byte (command = 0) or one timer tick (command = 1), and each produces exactly
// one result transfer carrying a status code plus the current PAN id and
// 64-bit device address. A frame is a length byte (0 means 256) followed by
// that many payload bytes; payload byte 0 selects the command when the frame
// completes. Ticks after the length byte count toward timeout_ticks, at which
// the partial frame is dropped. Throughput is one transfer per cycle while
// the result channel is not blocked. An accepted item is loaded into the
// input register, then passes through the framing/decode logic into the
// output register, whose loading raises result valid. The next item is taken
// while a result waits, as long as the input register is free. Configuration
// writes (cfg_we) are registered into the config registers and should only
// happen while idle. Only the first nine payload bytes are ever decoded, so
// only those are kept; BUFFER_DEPTH sets where overflow starts.

module length_prefixed_command_receiver import lpcr_pkg::*; #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] pan_id,
	output logic [63:0] device_address,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// config registers
	logic [7:0]  pan_code_q;
	logic [7:0]  addr_code_q;
	logic [7:0]  commit_code_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_code_q    <= 8'd0;
			addr_code_q   <= 8'd1;
			commit_code_q <= 8'd2;
			timeout_q     <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAN_CODE:  pan_code_q    <= cfg_wdata[7:0];
				REG_ADDR_CODE: addr_code_q   <= cfg_wdata[7:0];
				REG_COMMIT:    commit_code_q <= cfg_wdata[7:0];
				REG_TIMEOUT:   timeout_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register stage
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] byte_s1;
	logic       advance;   // s1 item is processed into the output register

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			byte_s1    <= data_byte;
		end
	end

	// framing and decode
	frm_res_t    frm;
	logic [2:0]  status_d;
	logic [15:0] pan_d;
	logic [63:0] addr_d;

	lpcr_framer #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.command      (command_s1),
		.data_byte    (byte_s1),
		.timeout_ticks(timeout_q),
		.res          (frm)
	);

	lpcr_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.frm         (frm),
		.pan_id_code (pan_code_q),
		.address_code(addr_code_q),
		.commit_code (commit_code_q),
		.status      (status_d),
		.pan_next    (pan_d),
		.addr_next   (addr_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid      <= 1'b0;
			status         <= ST_NOTHING;
			pan_id         <= 16'd0;
			device_address <= 64'd0;
		end else begin
			if (advance) begin
				out_valid      <= 1'b1;
				status         <= status_d;
				pan_id         <= pan_d;
				device_address <= addr_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// a tick can only report nothing or a timeout
	a_tick_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance && command_s1 |=> status == ST_NOTHING || status == ST_TIMEOUT)
		else $error("tick produced a byte or command status");

	// stored PAN id only moves with a PAN update result
	a_pan_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pan_id == $past(pan_id) || status == ST_PAN)
		else $error("PAN id changed without PAN update");

	// stored address only moves with an address update result
	a_addr_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> device_address == $past(device_address) || status == ST_ADDRESS)
		else $error("address changed without address update");

	// input stalls only when both stages are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without backpressure");

endmodule
